### design/kit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kit_pkg: shared types and constants for the keyword and identifier tokenizer
// Token kinds, character codes and the fixed keyword table with its lookup.
// ----------------------------------------------------------------------------
package kit_pkg;

  typedef logic [2:0] kind_t;
  typedef logic [7:0] byte_t;

  localparam kind_t KIND_OP    = 3'd0;
  localparam kind_t KIND_KW    = 3'd1;
  localparam kind_t KIND_ID    = 3'd2;
  localparam kind_t KIND_BAD   = 3'd3;
  localparam kind_t KIND_EOL   = 3'd4;
  localparam kind_t KIND_FULL  = 3'd5;

  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_COMMA = 8'h2C;
  localparam byte_t CH_SEMI  = 8'h3B;
  localparam byte_t CH_DOLLAR = 8'h24;
  localparam byte_t CH_PLUS  = 8'h2B;
  localparam byte_t CH_MINUS = 8'h2D;
  localparam byte_t CH_SLASH = 8'h2F;
  localparam byte_t CH_STAR  = 8'h2A;
  localparam byte_t CH_PCT   = 8'h25;
  localparam byte_t CH_EQ    = 8'h3D;

  localparam byte_t FIRST_ID = 8'd25;
  localparam int    KW_TOTAL = 23;

  // literal text: first character in the highest used byte
  localparam logic [63:0] KW_TEXT [KW_TOTAL] = '{
    64'("if"), 64'("else"), 64'("while"), 64'("do"), 64'("break"),
    64'("continue"), 64'("int"), 64'("double"), 64'("float"), 64'("return"),
    64'("case"), 64'("char"), 64'("sizeof"), 64'("long"), 64'("short"),
    64'("typedef"), 64'("switch"), 64'("unsigned"), 64'("void"), 64'("static"),
    64'("struct"), 64'("goto"), 64'("main")
  };
  localparam logic [3:0] KW_LEN [KW_TOTAL] = '{
    4'd2, 4'd4, 4'd5, 4'd2, 4'd5, 4'd8, 4'd3, 4'd6, 4'd5, 4'd6, 4'd4, 4'd4,
    4'd6, 4'd4, 4'd5, 4'd7, 4'd6, 4'd8, 4'd4, 4'd6, 4'd6, 4'd4, 4'd4
  };
  localparam logic [4:0] KW_NUM [KW_TOTAL] = '{
    5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd12, 5'd13,
    5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24
  };

  // w holds the word with its first character in the lowest byte; zero if no match
  function automatic logic [4:0] kw_lookup(input logic [63:0] w, input logic [4:0] n);
    logic [4:0] num;
    logic       hit;
    num = '0;
    for (int k = 0; k < KW_TOTAL; k++) begin
      hit = (n == {1'b0, KW_LEN[k]});
      for (int j = 0; j < 8; j++) begin
        if (j < int'(KW_LEN[k])) begin
          hit = hit && (w[8*j +: 8] == KW_TEXT[k][8*(int'(KW_LEN[k]) - 1 - j) +: 8]);
        end
      end
      if (hit && num == '0) begin
        num = KW_NUM[k];
      end
    end
    return num;
  endfunction

endpackage

### design/keyword_identifier_tokenizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_identifier_tokenizer_unit: byte-serial lexer with a name store
// Emits operator, keyword, identifier, error and end-of-line tokens.
// ----------------------------------------------------------------------------
// A word end holds off input while the word is resolved: a keyword or invalid word is
// emitted directly, a known name after one store read and one compare per stored name
// tried, and a new name or a full store only after all stored names were compared; a
// newline then adds an end-of-line token. Input is also held while a result stalls.
// Reset (rst_n low, synchronous) empties the word buffer and name count, sets line to 1.
module keyword_identifier_tokenizer_unit #(
  parameter int MAX_WORD  = 20,
  parameter int MAX_NAMES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [2:0] token_kind, [10:3] token_code, [26:11] line
  output logic        out_tlast
);

  localparam int WL = $clog2(MAX_WORD + 1);
  localparam int WI = $clog2(MAX_WORD);
  localparam int NU = $clog2(MAX_NAMES + 1);
  localparam int NI = $clog2(MAX_NAMES);
  localparam int EW = MAX_WORD * 8 + WL;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_KW   = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_MISS = 3'd4;
  localparam logic [2:0] S_EOL  = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [WL-1:0] word_len_r, word_len_nxt;
  logic [7:0]  word_chars_r [MAX_WORD];
  logic [NU-1:0] names_used_r, names_used_nxt;
  logic [NI-1:0] idx_r, idx_nxt;
  logic [15:0] line_r, line_nxt;
  logic        nl_r, nl_nxt;
  logic        out_tvalid_r, out_tvalid_nxt;
  logic [2:0]  out_kind_r, out_kind_nxt;
  logic [7:0]  out_code_r, out_code_nxt;
  logic [15:0] out_line_r, out_line_nxt;
  logic        out_last_r, out_last_nxt;

  logic [EW-1:0] name_mem [MAX_NAMES];
  logic [EW-1:0] rd_r;
  logic          mem_we;
  logic          word_we;

  logic [MAX_WORD*8-1:0] word_flat;
  logic [7:0]  ch;
  logic        accept, slot_free;
  logic        is_op, is_alnum, is_delim, is_digit0;
  logic [4:0]  kw_num;

  assign ch        = in_tdata;
  assign slot_free = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && slot_free;
  assign accept    = in_tvalid && in_tready;

  assign is_op = (ch == kit_pkg::CH_PLUS) || (ch == kit_pkg::CH_MINUS) ||
                 (ch == kit_pkg::CH_SLASH) || (ch == kit_pkg::CH_STAR) ||
                 (ch == kit_pkg::CH_PCT) || (ch == kit_pkg::CH_EQ);
  assign is_alnum = (ch >= "0" && ch <= "9") || (ch >= "A" && ch <= "Z") ||
                    (ch >= "a" && ch <= "z");
  assign is_delim = (ch == kit_pkg::CH_COMMA) || (ch == kit_pkg::CH_SEMI) ||
                    (ch == kit_pkg::CH_SPACE) || (ch == kit_pkg::CH_LF) ||
                    (ch == kit_pkg::CH_DOLLAR);

  // zero the bytes past the word length so stale buffer bytes never compare
  always_comb begin
    for (int i = 0; i < MAX_WORD; i++) begin
      word_flat[8*i +: 8] = (i < int'(word_len_r)) ? word_chars_r[i] : 8'h00;
    end
  end

  assign is_digit0 = (word_flat[7:0] >= "0") && (word_flat[7:0] <= "9");
  assign kw_num    = kit_pkg::kw_lookup(word_flat[63:0], 5'(word_len_r));

  always_comb begin
    state_nxt      = state_r;
    word_len_nxt   = word_len_r;
    names_used_nxt = names_used_r;
    idx_nxt        = idx_r;
    line_nxt       = line_r;
    nl_nxt         = nl_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_kind_nxt   = out_kind_r;
    out_code_nxt   = out_code_r;
    out_line_nxt   = out_line_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    word_we        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (is_op) begin
            out_tvalid_nxt = 1'b1;
            out_kind_nxt   = kit_pkg::KIND_OP;
            out_code_nxt   = ch;
            out_line_nxt   = line_r;
            out_last_nxt   = 1'b1;
          end else if (is_alnum) begin
            if (int'(word_len_r) < MAX_WORD) begin
              word_we      = 1'b1;
              word_len_nxt = word_len_r + WL'(1);
            end
          end else if (is_delim) begin
            nl_nxt = (ch == kit_pkg::CH_LF);
            if (word_len_r != '0) begin
              state_nxt = S_KW;
            end else if (ch == kit_pkg::CH_LF) begin
              out_tvalid_nxt = 1'b1;
              out_kind_nxt   = kit_pkg::KIND_EOL;
              out_code_nxt   = '0;
              out_line_nxt   = line_r;
              out_last_nxt   = 1'b1;
              line_nxt       = line_r + 16'd1;
            end
          end
        end
      end
      S_KW: begin
        if (slot_free) begin
          out_line_nxt = line_r;
          out_last_nxt = !nl_r;
          if (kw_num != '0) begin
            out_tvalid_nxt = 1'b1;
            out_kind_nxt   = kit_pkg::KIND_KW;
            out_code_nxt   = 8'(kw_num);
            word_len_nxt   = '0;
            state_nxt      = nl_r ? S_EOL : S_IDLE;
          end else if (is_digit0) begin
            out_tvalid_nxt = 1'b1;
            out_kind_nxt   = kit_pkg::KIND_BAD;
            out_code_nxt   = '0;
            word_len_nxt   = '0;
            state_nxt      = nl_r ? S_EOL : S_IDLE;
          end else if (names_used_r == '0) begin
            state_nxt = S_MISS;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (rd_r == {word_len_r, word_flat}) begin
          if (slot_free) begin
            out_tvalid_nxt = 1'b1;
            out_kind_nxt   = kit_pkg::KIND_ID;
            out_code_nxt   = kit_pkg::FIRST_ID + 8'(idx_r);
            out_line_nxt   = line_r;
            out_last_nxt   = !nl_r;
            word_len_nxt   = '0;
            state_nxt      = nl_r ? S_EOL : S_IDLE;
          end
        end else if (NU'(idx_r) + NU'(1) == names_used_r) begin
          state_nxt = S_MISS;
        end else begin
          idx_nxt   = idx_r + NI'(1);
          state_nxt = S_RD;
        end
      end
      S_MISS: begin
        if (slot_free) begin
          out_tvalid_nxt = 1'b1;
          out_line_nxt   = line_r;
          out_last_nxt   = !nl_r;
          word_len_nxt   = '0;
          state_nxt      = nl_r ? S_EOL : S_IDLE;
          if (names_used_r == NU'(MAX_NAMES)) begin
            out_kind_nxt = kit_pkg::KIND_FULL;
            out_code_nxt = '0;
          end else begin
            mem_we         = 1'b1;
            out_kind_nxt   = kit_pkg::KIND_ID;
            out_code_nxt   = kit_pkg::FIRST_ID + 8'(names_used_r);
            names_used_nxt = names_used_r + NU'(1);
          end
        end
      end
      S_EOL: begin
        if (slot_free) begin
          out_tvalid_nxt = 1'b1;
          out_kind_nxt   = kit_pkg::KIND_EOL;
          out_code_nxt   = '0;
          out_line_nxt   = line_r;
          out_last_nxt   = 1'b1;
          line_nxt       = line_r + 16'd1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      word_len_r   <= '0;
      names_used_r <= '0;
      idx_r        <= '0;
      line_r       <= 16'd1;
      nl_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      word_len_r   <= word_len_nxt;
      names_used_r <= names_used_nxt;
      idx_r        <= idx_nxt;
      line_r       <= line_nxt;
      nl_r         <= nl_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_code_r <= out_code_nxt;
    out_line_r <= out_line_nxt;
    out_last_r <= out_last_nxt;
    if (word_we) begin
      word_chars_r[word_len_r[WI-1:0]] <= ch;
    end
  end

  // name store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      name_mem[names_used_r[NI-1:0]] <= {word_len_r, word_flat};
    end
    rd_r <= name_mem[idx_r];
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'd0, out_line_r, out_code_r, out_kind_r};
  assign out_tlast  = out_last_r;

endmodule

### design/kit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kit_checker: port-level checks for the tokenizer
// Watches held result items, operator tokens and well-formed token codes.
// ----------------------------------------------------------------------------
module kit_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result item changed");

  a_op_token: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata == kit_pkg::CH_PLUS || in_tdata == kit_pkg::CH_EQ)
    |=> out_tvalid && out_tdata[2:0] == kit_pkg::KIND_OP && out_tdata[10:3] == $past(in_tdata))
    else $error("operator item not emitted at once");

  a_eol_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == kit_pkg::KIND_EOL |-> out_tlast && out_tdata[10:3] == 8'd0)
    else $error("end-of-line token malformed");

  a_kw_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == kit_pkg::KIND_KW
    |-> out_tdata[10:3] != 8'd0 && out_tdata[10:3] != 8'd11 && out_tdata[10:3] <= 8'd24)
    else $error("keyword number out of table");

  a_id_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == kit_pkg::KIND_ID |-> out_tdata[10:3] >= kit_pkg::FIRST_ID)
    else $error("identifier id below first id");

endmodule

bind keyword_identifier_tokenizer_unit kit_checker u_kit_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

### verif/keyword_identifier_tokenizer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_identifier_tokenizer_unit_tb: token stream check for the lexer
// Drives source bytes (directed text, then random words, operators and noise),
// predicts every token in a local lexer model and compares each output item.
// ----------------------------------------------------------------------------
module keyword_identifier_tokenizer_unit_tb;

  localparam int WORD_MAX  = 20;
  localparam int NAMES_MAX = 64;
  localparam int NUM_RANDOM = 240;
  localparam int HOLD_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  code;
    logic [15:0] line;
    logic        last;
  } token_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;

  keyword_identifier_tokenizer_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // lexer model state
  kit_pkg::byte_t word_buf [WORD_MAX];
  int     word_len = 0;
  kit_pkg::byte_t names [NAMES_MAX][WORD_MAX];
  int     name_len [NAMES_MAX];
  int     names_count = 0;
  logic [15:0] line_no = 16'd1;

  kit_pkg::byte_t pending_bytes [$];
  token_t expected_tokens [$];
  int     errors = 0;
  bit     sender_hold = 0;
  longint cycles = 0;
  int     rx_hold_reqs = 0;
  bit     in_taken = 0;
  bit     out_taken = 0;

  string kw_words [23] = '{"if", "else", "while", "do", "break", "continue", "int",
    "double", "float", "return", "case", "char", "sizeof", "long", "short",
    "typedef", "switch", "unsigned", "void", "static", "struct", "goto", "main"};
  int kw_codes [23] = '{1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 12, 13, 14, 15, 16, 17,
    18, 19, 20, 21, 22, 23, 24};

  function automatic token_t make_token(logic [2:0] kind, logic [7:0] code);
    token_t t;
    t.kind = kind;
    t.code = code;
    t.line = line_no;
    t.last = 1'b0;
    return t;
  endfunction

  function automatic token_t close_word();
    int n;
    bit hit;
    n = word_len;
    word_len = 0;
    foreach (kw_words[k]) begin
      if (kw_words[k].len() == n) begin
        hit = 1;
        for (int j = 0; j < n; j++) if (kw_words[k][j] != word_buf[j]) hit = 0;
        if (hit) return make_token(kit_pkg::KIND_KW, 8'(kw_codes[k]));
      end
    end
    if (word_buf[0] >= "0" && word_buf[0] <= "9") return make_token(kit_pkg::KIND_BAD, 8'd0);
    for (int i = 0; i < names_count; i++) begin
      if (name_len[i] == n) begin
        hit = 1;
        for (int j = 0; j < n; j++) if (names[i][j] != word_buf[j]) hit = 0;
        if (hit) return make_token(kit_pkg::KIND_ID, 8'(int'(kit_pkg::FIRST_ID) + i));
      end
    end
    if (names_count >= NAMES_MAX) return make_token(kit_pkg::KIND_FULL, 8'd0);
    for (int j = 0; j < n; j++) names[names_count][j] = word_buf[j];
    name_len[names_count] = n;
    names_count++;
    return make_token(kit_pkg::KIND_ID, 8'(int'(kit_pkg::FIRST_ID) + names_count - 1));
  endfunction

  task automatic predict_tokens(kit_pkg::byte_t c);
    token_t toks [$];
    if (c == kit_pkg::CH_PLUS || c == kit_pkg::CH_MINUS || c == kit_pkg::CH_SLASH ||
        c == kit_pkg::CH_STAR || c == kit_pkg::CH_PCT || c == kit_pkg::CH_EQ) begin
      toks = {toks, make_token(kit_pkg::KIND_OP, c)};
    end else if ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                 (c >= "a" && c <= "z")) begin
      if (word_len < WORD_MAX) begin
        word_buf[word_len] = c;
        word_len++;
      end
    end else if (c == kit_pkg::CH_COMMA || c == kit_pkg::CH_SEMI || c == kit_pkg::CH_SPACE ||
                 c == kit_pkg::CH_LF || c == kit_pkg::CH_DOLLAR) begin
      if (word_len != 0) toks = {toks, close_word()};
      if (c == kit_pkg::CH_LF) begin
        toks = {toks, make_token(kit_pkg::KIND_EOL, 8'd0)};
        line_no = line_no + 16'd1;
      end
    end
    if (toks.size() > 0) toks[toks.size() - 1].last = 1'b1;
    expected_tokens = {expected_tokens, toks};
  endtask

  task automatic queue_byte(kit_pkg::byte_t b);
    pending_bytes = {pending_bytes, b};
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(kit_pkg::byte_t'(s[i]));
  endtask

  function automatic kit_pkg::byte_t rand_alnum();
    case ($urandom_range(0, 2))
      0: return kit_pkg::byte_t'($urandom_range("a", "z"));
      1: return kit_pkg::byte_t'($urandom_range("A", "Z"));
      default: return kit_pkg::byte_t'($urandom_range("0", "9"));
    endcase
  endfunction

  function automatic kit_pkg::byte_t rand_delim();
    kit_pkg::byte_t d [5] = '{kit_pkg::CH_COMMA, kit_pkg::CH_SEMI, kit_pkg::CH_SPACE,
                              kit_pkg::CH_LF, kit_pkg::CH_DOLLAR};
    return d[$urandom_range(0, 4)];
  endfunction

  function automatic kit_pkg::byte_t rand_op();
    kit_pkg::byte_t o [6] = '{kit_pkg::CH_PLUS, kit_pkg::CH_MINUS, kit_pkg::CH_SLASH,
                              kit_pkg::CH_STAR, kit_pkg::CH_PCT, kit_pkg::CH_EQ};
    return o[$urandom_range(0, 5)];
  endfunction

  // input handshake seen at the rising edge; predict as the byte is taken
  always @(posedge clk) begin
    in_taken = rst_n && in_tvalid && in_tready;
    if (in_taken) predict_tokens(in_tdata);
  end

  // driver: offer the next byte after a random gap
  int tx_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) tx_gap = $urandom_range(0, 1) == 0 ? 0 : $urandom_range(0, 18);
      if (!in_tvalid || in_taken) begin
        if (tx_gap > 0 || sender_hold || pending_bytes.size() == 0) begin
          if (tx_gap > 0) tx_gap--;
          in_tvalid <= 1'b0;
        end else begin
          in_tdata  <= pending_bytes.pop_front();
          in_tvalid <= 1'b1;
        end
      end
    end
  end

  // receiver stall, counted separately so a long hold-off can be requested
  int rx_gap = 0;
  int rx_hold_cycles = 0;
  int rx_hold_seen = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (rx_hold_seen != rx_hold_reqs) begin
        rx_hold_seen   = rx_hold_reqs;
        rx_hold_cycles = HOLD_CYCLES;
      end
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        out_tready <= 1'b0;
      end else begin
        if (out_taken) rx_gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18);
        if (rx_gap > 0) begin
          rx_gap--;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    token_t got, want;
    cycles++;
    out_taken = rst_n && out_tvalid && out_tready;
    if (out_taken) begin
      got.kind = out_tdata[2:0];
      got.code = out_tdata[10:3];
      got.line = out_tdata[26:11];
      got.last = out_tlast;
      if (expected_tokens.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected token kind %0d code %0d line %0d",
                                   got.kind, got.code, got.line);
      end else begin
        want = expected_tokens.pop_front();
        if (got != want) begin
          errors++;
          if (errors <= 10)
            $display("token mismatch: exp kind %0d code %0d line %0d last %0b, got %0d %0d %0d %0b",
                     want.kind, want.code, want.line, want.last,
                     got.kind, got.code, got.line, got.last);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL keyword_identifier_tokenizer_unit");
      $finish;
    end
  end

  initial begin
    int wl;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: operators, keywords, leading digit, joins, long word, noise
    add_text("+-/*%=\n");
    foreach (kw_words[k]) begin
      add_text(kw_words[k]);
      queue_byte(rand_delim());
    end
    add_text("chars 9lives x1 x1;a+b,");
    add_text("abcdefghijklmnopqrstuvwxyz0123456789 abcdefghijklmnopqrstXYZ$");
    add_text(",;$  \n\n");
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h80);
    queue_byte(8'h7F);
    add_text("Zz09 zZ90\n");
    wait (pending_bytes.size() == 0 && !in_tvalid);

    // receiver holds off while sender keeps offering
    rx_hold_reqs++;
    for (int i = 0; i < 30; i++) begin
      queue_byte(rand_op());
      add_text("q ");
    end
    wait (pending_bytes.size() == 0 && !in_tvalid);
    sender_hold = 1;
    wait (expected_tokens.size() == 0);
    sender_hold = 0;

    // random words with some noise; fill the name store over time
    while (pending_bytes.size() < NUM_RANDOM) begin
      case ($urandom_range(0, 9))
        0: queue_byte(kit_pkg::byte_t'($urandom_range(0, 255)));
        1: queue_byte(rand_op());
        2: begin
          add_text(kw_words[$urandom_range(0, 22)]);
          queue_byte(rand_delim());
        end
        default: begin
          wl = $urandom_range(0, 9) == 0 ? $urandom_range(15, 24) : $urandom_range(1, 3);
          for (int j = 0; j < wl; j++) begin
            if ($urandom_range(0, 15) == 0) queue_byte(rand_op());
            queue_byte(rand_alnum());
          end
          queue_byte(rand_delim());
        end
      endcase
    end
    // a final batch of fresh names, past the store limit
    for (int i = 0; i < NAMES_MAX + 4; i++) begin
      add_text($sformatf("n%0d ", i));
    end
    queue_byte(kit_pkg::CH_LF);

    wait (pending_bytes.size() == 0 && !in_tvalid);
    wait (expected_tokens.size() == 0);
    repeat (2 * NAMES_MAX + 20) @(posedge clk);
    if (errors == 0 && expected_tokens.size() == 0) begin
      $display("PASS keyword_identifier_tokenizer_unit");
    end else begin
      $display("FAIL keyword_identifier_tokenizer_unit");
    end
    $finish;
  end

endmodule
